FILE: rtl/pfwrl_pkg.sv
// Shared types and codes for the per-user fixed-window rate limiter.
package pfwrl_pkg;

  localparam int USER_W     = 32;
  localparam int TIME_W     = 64;
  localparam int WINDOW_W   = 32;
  localparam int ATTEMPT_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 1'd1;

  localparam logic [WINDOW_W-1:0]  WINDOW_RESET = 32'd60000;
  localparam logic [ATTEMPT_W-1:0] LIMIT_RESET  = 16'd5;

  // Deny reason codes.
  localparam logic [1:0] REASON_NONE      = 2'd0;
  localparam logic [1:0] REASON_BACKWARD  = 2'd1;
  localparam logic [1:0] REASON_NO_BUCKET = 2'd2;
  localparam logic [1:0] REASON_LIMIT     = 2'd3;

  typedef struct packed {
    logic [USER_W-1:0]    user;
    logic [TIME_W-1:0]    win_start;
    logic [ATTEMPT_W-1:0] attempts;
  } bucket_t;

  typedef struct packed {
    logic    en;
    bucket_t entry;
  } bucket_wr_t;

  typedef struct packed {
    logic hit;
    logic avail;
    logic over;
  } eval_t;

endpackage

FILE: rtl/pfwrl_ifs.sv
// Request and result channel interfaces of the rate limiter.
interface pfwrl_req_if;
  logic                        valid;
  logic                        ready;
  logic [pfwrl_pkg::USER_W-1:0] user_id;
  logic [pfwrl_pkg::TIME_W-1:0] now_time;

  modport source (output valid, output user_id, output now_time, input ready);
  modport sink (input valid, input user_id, input now_time, output ready);
endinterface

interface pfwrl_rsp_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [1:0] deny_reason;

  modport source (output valid, output allowed, output deny_reason, input ready);
  modport sink (input valid, input allowed, input deny_reason, output ready);
endinterface

FILE: rtl/pfwrl_bucket_cmp.sv
// Shared bucket compare unit: user match and 64-bit window expiry test.
module pfwrl_bucket_cmp (
  input  logic                           in_use,
  input  pfwrl_pkg::bucket_t             entry,
  input  logic [pfwrl_pkg::USER_W-1:0]   user,
  input  logic [pfwrl_pkg::TIME_W-1:0]   now,
  input  logic [pfwrl_pkg::WINDOW_W-1:0] window_length,
  output pfwrl_pkg::eval_t               result
);

  logic [pfwrl_pkg::TIME_W-1:0] elapsed;
  logic                         over;

  // Elapsed time wraps modulo 2^64, as a free-running clock would.
  assign elapsed = now - entry.win_start;
  assign over    = elapsed >= {{(pfwrl_pkg::TIME_W - pfwrl_pkg::WINDOW_W){1'b0}}, window_length};

  assign result.hit   = in_use && (entry.user == user);
  assign result.avail = !in_use || over;
  assign result.over  = over;

endmodule

FILE: rtl/pfwrl_bucket_ram.sv
// Bucket table: one-port-read, one-port-write memory plus in-use flags.
module pfwrl_bucket_ram #(
  parameter int BUCKET_COUNT = 16,
  parameter int IDX_W        = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [IDX_W-1:0]       rd_addr,
  output pfwrl_pkg::bucket_t     rd_entry,
  output logic                   rd_in_use,
  input  logic [IDX_W-1:0]       wr_addr,
  input  pfwrl_pkg::bucket_wr_t  wr
);

  pfwrl_pkg::bucket_t      mem_r [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] in_use_r;
  pfwrl_pkg::bucket_t      rd_entry_r;
  logic                    rd_in_use_r;

  // Entry contents are only meaningful while the in-use flag is set.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr_addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      rd_in_use_r <= 1'b0;
    end else begin
      if (wr.en) begin
        in_use_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_in_use_r <= in_use_r[rd_addr];
      end
    end
  end

  assign rd_entry  = rd_entry_r;
  assign rd_in_use = rd_in_use_r;

endmodule

FILE: rtl/per_user_fixed_window_rate_limiter.sv
// Per-user fixed-window rate limiter: configuration, sequencer and result register.
//
// Usage: each beat on in_req carries a user id and a monotonic time in
// milliseconds; each request yields exactly one beat on out_rsp with an
// allowed flag and a deny reason. The block takes one request at a time:
// in_req.ready is high only while the sequencer is idle. A request that
// scans the whole table reads every bucket before its result reaches the
// result register; the scan stops early when the request's user is found,
// and a request whose time went backwards skips the scan and goes straight
// to the result register. The length of a scan is set by the bucket table,
// which is read one bucket per cycle through its single read port into one
// shared compare unit. A new request is accepted while a finished result
// still waits in the output register; a stalled receiver holds the result
// there, and the next request then waits before its result is loaded.
// Configuration writes through cfg_we/cfg_index/cfg_wdata take effect at
// once and belong to idle periods. Reset restores window_length 60000 and
// attempt_limit 5, clears the latest time and marks every bucket free in
// the same cycle; no clearing pass is needed.
module per_user_fixed_window_rate_limiter #(
  parameter int BUCKET_COUNT = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pfwrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfwrl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  pfwrl_req_if.sink                        in_req,
  pfwrl_rsp_if.source                      out_rsp
);

  localparam int IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int CNT_W = $clog2(BUCKET_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(BUCKET_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUCKET_COUNT - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [pfwrl_pkg::WINDOW_W-1:0]  window_length_r;
  logic [pfwrl_pkg::ATTEMPT_W-1:0] attempt_limit_r;
  logic [pfwrl_pkg::TIME_W-1:0]    latest_r, latest_nxt;

  logic [pfwrl_pkg::USER_W-1:0] user_r, user_nxt;
  logic [pfwrl_pkg::TIME_W-1:0] now_r, now_nxt;

  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0] ev_idx_r, ev_idx_nxt;

  logic               found_r, found_nxt;
  logic               match_r, match_nxt;
  logic               match_over_r, match_over_nxt;
  logic [IDX_W-1:0]   pick_r, pick_nxt;
  pfwrl_pkg::bucket_t pick_entry_r, pick_entry_nxt;

  logic       res_allowed_r, res_allowed_nxt;
  logic [1:0] res_reason_r, res_reason_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_allowed_r, out_allowed_nxt;
  logic [1:0] out_reason_r, out_reason_nxt;

  logic                  rd_en;
  pfwrl_pkg::bucket_t    rd_entry;
  logic                  rd_in_use;
  pfwrl_pkg::bucket_wr_t wr;
  pfwrl_pkg::eval_t      ev;

  logic                            in_fire;
  logic                            out_free;
  logic                            restart;
  logic [pfwrl_pkg::ATTEMPT_W-1:0] att_eff;

  pfwrl_bucket_ram #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .IDX_W       (IDX_W)
  ) u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (iss_r[IDX_W-1:0]),
    .rd_entry (rd_entry),
    .rd_in_use(rd_in_use),
    .wr_addr  (pick_r),
    .wr       (wr)
  );

  pfwrl_bucket_cmp u_cmp (
    .in_use       (rd_in_use),
    .entry        (rd_entry),
    .user         (user_r),
    .now          (now_r),
    .window_length(window_length_r),
    .result       (ev)
  );

  assign in_req.ready        = (state_r == ST_IDLE);
  assign in_fire             = in_req.valid && in_req.ready;
  assign out_free            = !out_valid_r || out_rsp.ready;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.allowed     = out_allowed_r;
  assign out_rsp.deny_reason = out_reason_r;

  assign rd_en   = (state_r == ST_SCAN) && (iss_r < CNT_END);
  // A same-user bucket keeps its window unless it has expired; any other pick starts fresh.
  assign restart = !match_r || match_over_r;
  assign att_eff = restart ? '0 : pick_entry_r.attempts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= pfwrl_pkg::WINDOW_RESET;
      attempt_limit_r <= pfwrl_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfwrl_pkg::CFG_WINDOW_LENGTH: window_length_r <= cfg_wdata;
        pfwrl_pkg::CFG_ATTEMPT_LIMIT: attempt_limit_r <= cfg_wdata[pfwrl_pkg::ATTEMPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    latest_nxt      = latest_r;
    user_nxt        = user_r;
    now_nxt         = now_r;
    iss_nxt         = iss_r;
    ev_vld_nxt      = 1'b0;
    ev_idx_nxt      = ev_idx_r;
    found_nxt       = found_r;
    match_nxt       = match_r;
    match_over_nxt  = match_over_r;
    pick_nxt        = pick_r;
    pick_entry_nxt  = pick_entry_r;
    res_allowed_nxt = res_allowed_r;
    res_reason_nxt  = res_reason_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_allowed_nxt = out_allowed_r;
    out_reason_nxt  = out_reason_r;
    wr.en           = 1'b0;
    wr.entry        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          user_nxt  = in_req.user_id;
          now_nxt   = in_req.now_time;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        iss_nxt   = '0;
        found_nxt = 1'b0;
        match_nxt = 1'b0;
        if (now_r < latest_r) begin
          res_allowed_nxt = 1'b0;
          res_reason_nxt  = pfwrl_pkg::REASON_BACKWARD;
          state_nxt       = ST_FINISH;
        end else begin
          latest_nxt = now_r;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          iss_nxt    = iss_r + 1'b1;
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = iss_r[IDX_W-1:0];
        end
        if (ev_vld_r) begin
          if (ev.hit) begin
            found_nxt      = 1'b1;
            match_nxt      = 1'b1;
            match_over_nxt = ev.over;
            pick_nxt       = ev_idx_r;
            pick_entry_nxt = rd_entry;
            ev_vld_nxt     = 1'b0;
            state_nxt      = ST_DECIDE;
          end else begin
            if (ev.avail && !found_r) begin
              found_nxt      = 1'b1;
              pick_nxt       = ev_idx_r;
              pick_entry_nxt = rd_entry;
            end
            if (ev_idx_r == IDX_LAST) begin
              ev_vld_nxt = 1'b0;
              state_nxt  = ST_DECIDE;
            end
          end
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_FINISH;
        if (!found_r) begin
          res_allowed_nxt = 1'b0;
          res_reason_nxt  = pfwrl_pkg::REASON_NO_BUCKET;
        end else if (att_eff >= attempt_limit_r) begin
          res_allowed_nxt      = 1'b0;
          res_reason_nxt       = pfwrl_pkg::REASON_LIMIT;
          wr.en                = restart;
          wr.entry.user        = user_r;
          wr.entry.win_start   = now_r;
          wr.entry.attempts    = '0;
        end else begin
          res_allowed_nxt      = 1'b1;
          res_reason_nxt       = pfwrl_pkg::REASON_NONE;
          wr.en                = 1'b1;
          wr.entry.user        = user_r;
          wr.entry.win_start   = restart ? now_r : pick_entry_r.win_start;
          wr.entry.attempts    = att_eff + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = res_allowed_r;
          out_reason_nxt  = res_reason_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      latest_r    <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      latest_r    <= latest_nxt;
      ev_vld_r    <= ev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    user_r        <= user_nxt;
    now_r         <= now_nxt;
    iss_r         <= iss_nxt;
    ev_idx_r      <= ev_idx_nxt;
    found_r       <= found_nxt;
    match_r       <= match_nxt;
    match_over_r  <= match_over_nxt;
    pick_r        <= pick_nxt;
    pick_entry_r  <= pick_entry_nxt;
    res_allowed_r <= res_allowed_nxt;
    res_reason_r  <= res_reason_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_reason_r  <= out_reason_nxt;
  end

endmodule
